FILE: src/ase_pkg.sv
package ase_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 128;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED    = 2'd0,
    ST_FULL      = 2'd1,
    ST_DELIVERED = 2'd2,
    ST_EMPTY     = 2'd3
  } ase_status_t;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic                     load;
    logic                     drain;
    logic signed [DATA_W-1:0] value;
  } ase_ctl_t;

endpackage

FILE: src/ase_if.sv
interface ase_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic signed [ase_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface ase_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ase_pkg::DATA_W-1:0] value_res;
  logic [1:0]                       status;
  logic                             last;

  modport source (output valid, output value_res, output status, output last, input ready);
  modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

FILE: src/ase_cell.sv
module ase_cell (
  input  logic                                  clk,
  input  ase_pkg::ase_ctl_t                     ctl,
  input  logic                                  occupied,
  input  logic                                  prev_gt,
  input  logic signed [ase_pkg::DATA_W-1:0]     prev_val,
  input  logic signed [ase_pkg::DATA_W-1:0]     next_val,
  output logic                                  gt,
  output logic signed [ase_pkg::DATA_W-1:0]     val
);

  logic signed [ase_pkg::DATA_W-1:0] val_r;
  logic signed [ase_pkg::DATA_W-1:0] val_nxt;

  // An empty cell counts as greater than any request, so a new value lands
  // at the first cell that is empty or holds a larger value.
  assign gt  = !occupied || (val_r > ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.load) begin
      if (prev_gt) begin
        val_nxt = prev_val;
      end else if (gt) begin
        val_nxt = ctl.value;
      end
    end else if (ctl.drain) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: src/ascending_sort_engine_top.sv
// All cells compare and shift in parallel; each result is registered and shown
// in the cycle after acceptance. One request per cycle while no result waits
// untaken. The output register frees itself in the cycle its result is taken.
// Reset (synchronous, active low) empties the store and the output register.
// Cell contents are not reset; only cells below the fill count are ever read.
module ascending_sort_engine_top #(
  parameter int CAPACITY = ase_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ase_in_if.sink           in_ch,
  ase_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]                    count_r;
  logic [CNT_W-1:0]                    count_nxt;
  logic signed [ase_pkg::DATA_W-1:0]   cell_val [CAPACITY];
  logic [CAPACITY-1:0]                 cell_gt;
  logic [CAPACITY-1:0]                 cell_occ;
  ase_pkg::ase_ctl_t                   ctl;
  logic                                accept;
  logic                                full;
  logic                                empty;

  logic                                out_valid_r;
  logic signed [ase_pkg::DATA_W-1:0]   value_res_r;
  logic signed [ase_pkg::DATA_W-1:0]   value_res_nxt;
  ase_pkg::ase_status_t                status_r;
  ase_pkg::ase_status_t                status_nxt;
  logic                                last_r;
  logic                                last_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign empty       = (count_r == '0);

  assign ctl.load  = accept && (in_ch.cmd == ase_pkg::CMD_LOAD) && !full;
  assign ctl.drain = accept && (in_ch.cmd == ase_pkg::CMD_DRAIN) && !empty;
  assign ctl.value = in_ch.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              prev_gt;
    logic signed [ase_pkg::DATA_W-1:0] prev_val;
    logic signed [ase_pkg::DATA_W-1:0] next_val;

    assign cell_occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_body
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_link
      assign next_val = cell_val[i+1];
    end

    ase_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (cell_occ[i]),
      .prev_gt  (prev_gt),
      .prev_val (prev_val),
      .next_val (next_val),
      .gt       (cell_gt[i]),
      .val      (cell_val[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.load) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.drain) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    value_res_nxt = '0;
    last_nxt      = 1'b0;
    if (in_ch.cmd == ase_pkg::CMD_LOAD) begin
      status_nxt = full ? ase_pkg::ST_FULL : ase_pkg::ST_LOADED;
    end else if (empty) begin
      status_nxt = ase_pkg::ST_EMPTY;
    end else begin
      status_nxt    = ase_pkg::ST_DELIVERED;
      value_res_nxt = cell_val[0];
      last_nxt      = (count_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_res_r <= value_res_nxt;
      status_r    <= status_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_res = value_res_r;
  assign out_ch.status    = status_r;
  assign out_ch.last      = last_r;

endmodule

FILE: src/ase_checker.sv
module ase_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ase_pkg::DATA_W-1:0] out_value_res,
  input logic [1:0]                        out_status,
  input logic                              out_last
);

  logic out_take;

  assign out_take = out_valid && out_ready;

  // A result that is not a delivered value carries zero and no last flag.
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ase_pkg::ST_DELIVERED)) |-> ((out_value_res == '0) && !out_last))
    else $error("non-delivery result carries data or last flag");

  // The block refuses a request only while an untaken result is held.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a pending result");

  // An accepted request always produces a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request produced no result");

  // A held result stays unchanged until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value_res)
                                   && $stable(out_status) && $stable(out_last)))
    else $error("stalled result changed");

  // A drain that reports empty cannot directly follow a delivered non-final value.
  a_empty_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && (out_status == ase_pkg::ST_DELIVERED) && !out_last) |=>
      !(out_take && (out_status == ase_pkg::ST_EMPTY)))
    else $error("empty reported while values remained");

endmodule

bind ascending_sort_engine_top ase_checker u_ase_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value_res (out_ch.value_res),
  .out_status    (out_ch.status),
  .out_last      (out_ch.last)
);
